// ----- rtl/assert_macros.svh -----
// assertion macros used by the datapath of the cache statistics block
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every edge outside reset
`define DMCS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define DMCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define DMCS_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define DMCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/dmcs_pkg.sv -----
// shared types and constants of the direct-mapped cache statistics block
// no dependencies
`default_nettype none

package dmcs_pkg;

    // field widths
    localparam int REQ_W        = 2;
    localparam int ADDR_W       = 32;
    localparam int CNT_W        = 32;
    localparam int BYTE_W       = 48;
    localparam int DIRTY_W      = 11;
    localparam int CACHE_LOG2_W = 5;
    localparam int BLOCK_LOG2_W = 4;
    localparam int BLK_BYTES_W  = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 304;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FETCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_POLICY = 2'd2;

    // reset geometry and policy
    localparam logic [CACHE_LOG2_W-1:0] CACHE_LOG2_RST = 5'd14;
    localparam logic [BLOCK_LOG2_W-1:0] BLOCK_LOG2_RST = 4'd5;
    localparam logic                    POLICY_WB      = 1'b0;
    localparam logic                    POLICY_WT      = 1'b1;

    // bytes sent to memory per write-through store
    localparam logic [BLK_BYTES_W:0] WT_WORD_BYTES = 17'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;   // zero one line of the tag memory
        logic load;    // capture the input transfer and read its line
        logic commit;  // update line, counters and result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;  // clear pass is at its final line
        logic out_free;    // result register can take a new result
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/dmcs_ctrl.sv -----
// controller of the cache statistics block: clear pass, load, commit
// depends on dmcs_pkg
`default_nettype none

module dmcs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  wire dmcs_pkg::t_sts i_sts,
    output dmcs_pkg::t_cmd      o_cmd
);
    import dmcs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load      = i_s_axis_tvalid;
            end
            ST_EVAL: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/dmcs_datapath.sv -----
// datapath of the cache statistics block: tag memory, counters, result register
// depends on dmcs_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module dmcs_datapath #(
    parameter int LINE_INDEX_BITS = 10,
    parameter int ADDRESS_BITS    = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [dmcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [dmcs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire  [dmcs_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    input  wire dmcs_pkg::t_cmd                 i_cmd,
    output dmcs_pkg::t_sts                      o_sts,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [dmcs_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    import dmcs_pkg::*;

    localparam int AW        = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int NUM_LINES = 1 << LINE_INDEX_BITS;
    localparam int DC_W      = LINE_INDEX_BITS + 1;
    localparam int ENT_W     = AW + 2;

    // configuration
    logic [CACHE_LOG2_W-1:0] r_cache_log2;
    logic [BLOCK_LOG2_W-1:0] r_block_log2;
    logic                    r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_log2 <= CACHE_LOG2_RST;
            r_block_log2 <= BLOCK_LOG2_RST;
            r_policy     <= POLICY_WB;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CACHE_LOG2:   r_cache_log2 <= i_cfg_wdata[CACHE_LOG2_W-1:0];
                CFG_BLOCK_LOG2:   r_block_log2 <= i_cfg_wdata[BLOCK_LOG2_W-1:0];
                CFG_WRITE_POLICY: r_policy     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // geometry of the incoming transfer
    logic [REQ_W-1:0]           in_req;
    logic [AW-1:0]              in_addr;
    logic [CACHE_LOG2_W:0]      geo_diff;
    logic [CACHE_LOG2_W-1:0]    idx_bits;
    logic [AW-1:0]              in_blk;
    logic [LINE_INDEX_BITS-1:0] idx_mask;
    logic [LINE_INDEX_BITS-1:0] in_line;
    logic [5:0]                 tag_shift;
    logic [AW-1:0]              in_tag;

    always_comb begin
        in_req   = i_s_axis_tdata[REQ_W-1:0];
        in_addr  = i_s_axis_tdata[REQ_W +: AW];
        geo_diff = {1'b0, r_cache_log2} - (CACHE_LOG2_W+1)'(r_block_log2);
        if (r_cache_log2 > CACHE_LOG2_W'(r_block_log2)) begin
            idx_bits = geo_diff[CACHE_LOG2_W-1:0];
        end else begin
            idx_bits = '0;
        end
        if (idx_bits > CACHE_LOG2_W'(LINE_INDEX_BITS)) begin
            idx_bits = CACHE_LOG2_W'(LINE_INDEX_BITS);
        end
        in_blk    = in_addr >> r_block_log2;
        idx_mask  = ~({LINE_INDEX_BITS{1'b1}} << idx_bits);
        in_line   = in_blk[LINE_INDEX_BITS-1:0] & idx_mask;
        tag_shift = 6'(r_block_log2) + 6'(idx_bits);
        in_tag    = in_addr >> tag_shift;
    end

    // captured transfer
    logic [REQ_W-1:0]           r_req;
    logic [AW-1:0]              r_tag;
    logic [LINE_INDEX_BITS-1:0] r_line;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= in_req;
            r_tag  <= in_tag;
            r_line <= in_line;
        end
    end

    // tag memory, entry is {valid, dirty, tag}
    logic [ENT_W-1:0]           mem [NUM_LINES];
    logic [ENT_W-1:0]           r_rd_entry;
    logic [ENT_W-1:0]           wr_entry;
    logic                       wr_en;
    logic [LINE_INDEX_BITS-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            mem[r_line] <= wr_entry;
        end
        if (i_cmd.load) begin
            r_rd_entry <= mem[in_line];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // lookup and update
    logic                   ent_valid;
    logic                   ent_dirty;
    logic [AW-1:0]          ent_tag;
    logic                   active;
    logic                   hit;
    logic                   miss;
    logic                   is_write;
    logic                   victim_wb;
    logic                   dirty_after;
    logic                   set_dirty;
    logic                   new_dirty;
    logic [BLK_BYTES_W-1:0] block_bytes;
    logic [BLK_BYTES_W:0]   fill_add;
    logic [BLK_BYTES_W:0]   out_add;

    always_comb begin
        ent_valid   = r_rd_entry[ENT_W-1];
        ent_dirty   = r_rd_entry[ENT_W-2];
        ent_tag     = r_rd_entry[AW-1:0];
        active      = (r_req != REQ_NONE);
        hit         = active && ent_valid && (ent_tag == r_tag);
        miss        = active && !hit;
        is_write    = (r_req == REQ_WRITE);
        victim_wb   = miss && ent_valid && ent_dirty;
        dirty_after = miss ? 1'b0 : ent_dirty;
        set_dirty   = is_write && (r_policy == POLICY_WB) && !dirty_after;
        new_dirty   = (is_write && (r_policy == POLICY_WB)) ? 1'b1 : dirty_after;
        wr_en       = i_cmd.commit && active;
        wr_entry    = {1'b1, new_dirty, r_tag};
        block_bytes = BLK_BYTES_W'(1) << r_block_log2;
        fill_add    = miss ? (BLK_BYTES_W+1)'(block_bytes) : '0;
        out_add     = (victim_wb ? (BLK_BYTES_W+1)'(block_bytes) : '0)
                    + ((is_write && (r_policy == POLICY_WT)) ? WT_WORD_BYTES : '0);
    end

    // statistics
    logic [CNT_W-1:0]  r_type_cnt [3];
    logic [CNT_W-1:0]  r_miss_cnt [3];
    logic [BYTE_W-1:0] r_fill_bytes;
    logic [BYTE_W-1:0] r_out_bytes;
    logic [DC_W-1:0]   r_dirty_cnt;
    logic              r_hit;
    logic              r_out_valid;

    logic [BYTE_W:0]   fill_sum;
    logic [BYTE_W:0]   out_sum;
    logic [DC_W-1:0]   dirty_dec;
    logic [DC_W-1:0]   n_dirty_cnt;

    always_comb begin
        fill_sum  = {1'b0, r_fill_bytes} + (BYTE_W+1)'(fill_add);
        out_sum   = {1'b0, r_out_bytes} + (BYTE_W+1)'(out_add);
        dirty_dec = (miss && ent_dirty && (r_dirty_cnt != '0))
                  ? r_dirty_cnt - 1'b1 : r_dirty_cnt;
        n_dirty_cnt = set_dirty ? dirty_dec + 1'b1 : dirty_dec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_type_cnt[i] <= '0;
                r_miss_cnt[i] <= '0;
            end
            r_fill_bytes <= '0;
            r_out_bytes  <= '0;
            r_dirty_cnt  <= '0;
            r_hit        <= 1'b0;
        end else if (i_cmd.commit) begin
            r_hit <= hit;
            for (int i = 0; i < 3; i++) begin
                if (active && (r_req == REQ_W'(i)) && (r_type_cnt[i] != '1)) begin
                    r_type_cnt[i] <= r_type_cnt[i] + 1'b1;
                end
                if (miss && (r_req == REQ_W'(i)) && (r_miss_cnt[i] != '1)) begin
                    r_miss_cnt[i] <= r_miss_cnt[i] + 1'b1;
                end
            end
            if (active) begin
                r_fill_bytes <= fill_sum[BYTE_W] ? '1 : fill_sum[BYTE_W-1:0];
                r_out_bytes  <= out_sum[BYTE_W] ? '1 : out_sum[BYTE_W-1:0];
                r_dirty_cnt  <= n_dirty_cnt;
            end
        end
    end

    // result register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.clear_last = (r_clr_addr == {LINE_INDEX_BITS{1'b1}});
        o_sts.out_free   = !r_out_valid || i_m_axis_tready;
        o_m_axis_tvalid  = r_out_valid;
        o_m_axis_tdata   = {4'b0000,
                            DIRTY_W'(r_dirty_cnt),
                            r_out_bytes,
                            r_fill_bytes,
                            r_miss_cnt[2],
                            r_miss_cnt[1],
                            r_miss_cnt[0],
                            r_type_cnt[2],
                            r_type_cnt[1],
                            r_type_cnt[0],
                            r_hit};
    end

    `DMCS_ASSERT_RST(a_commit_room, i_clk, i_rst_n,
        i_cmd.commit |-> (!r_out_valid || i_m_axis_tready),
        "commit while result register still full")
    `DMCS_ASSERT_RST(a_clear_alone, i_clk, i_rst_n,
        i_cmd.clear |-> !(i_cmd.load || i_cmd.commit),
        "transfer handled during clear pass")
    `DMCS_ASSERT_RST(a_dirty_bound, i_clk, i_rst_n,
        r_dirty_cnt <= DC_W'(NUM_LINES),
        "dirty count above line count")
    `DMCS_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n,
        i_cmd.commit, r_out_valid,
        "committed result not presented")

endmodule

`default_nettype wire

// ----- rtl/direct_mapped_cache_stats_top.sv -----
// top level of the direct-mapped cache statistics block
// depends on dmcs_pkg, dmcs_ctrl and dmcs_datapath
`default_nettype none

// Trace-driven direct-mapped cache model. Each slave transfer carries one
// reference (read, write or instruction fetch plus byte address); the block
// looks it up in a 2^LINE_INDEX_BITS-line tag memory holding tag, valid and
// dirty marks, applies write-back or write-through with write-allocate, and
// returns one master transfer with the hit flag and the saturating access,
// miss and byte counters plus the live dirty-line count. After reset the
// block walks the tag memory once to clear it, one line per cycle, and takes
// no transfer until that pass ends. Each reference then takes two steps:
// capture it and read its line from the tag memory, then check the tag and
// write the line and counters back, as the single-port tag memory must read
// before it writes. The result sits in an output register, so the next
// reference is taken while the previous result waits. The user must write
// configuration only when no reference is in flight; the block does not
// enforce this. Changing geometry does not flush the cache.

module direct_mapped_cache_stats_top #(
    parameter int LINE_INDEX_BITS = 10,
    parameter int ADDRESS_BITS    = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration writes: 0 cache_log2, 1 block_log2, 2 write_policy
    input  wire                              i_cfg_wr_en,
    input  wire  [dmcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [dmcs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // reference stream
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // req_type[1:0], address[33:2], zero pad [39:34]
    input  wire  [dmcs_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // hit[0], read_total[32:1], write_total[64:33], fetch_total[96:65],
    // read_misses[128:97], write_misses[160:129], fetch_misses[192:161],
    // bytes_filled[240:193], bytes_written_out[288:241],
    // dirty_lines[299:289], zero pad [303:300]
    output logic [dmcs_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);
    import dmcs_pkg::*;

    t_cmd cmd;   // controller commands
    t_sts sts;   // datapath status

    // sequencing: clear pass, capture, commit
    dmcs_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // tag memory, statistics and result register
    dmcs_datapath #(
        .LINE_INDEX_BITS (LINE_INDEX_BITS),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
